### design/sps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg: shared definitions for the stepper phase sequencer
// Register map codes, field widths, reset values and the coil code table.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int unsigned TICKS_PER_MINUTE_DEF = 60000;
  localparam int unsigned STEPS_PER_REV_DEF    = 100;

  localparam int unsigned MAX_RPM      = 30;
  localparam int unsigned PERIOD_W     = 10;
  localparam int unsigned PERIOD_MAX   = 1023;
  localparam int unsigned RESET_PERIOD = 20;
  localparam int unsigned RESET_SPEED  = 15;
  localparam int unsigned SPEED_W      = 6;
  localparam int unsigned RPM_W        = 5;
  localparam int unsigned PHASE_W      = 3;
  localparam int unsigned COIL_W       = 4;
  localparam int unsigned ADDR_W       = 4;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned REG_IDX_W    = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DIR   = 2'd0,
    REG_FULL  = 2'd1,
    REG_SPEED = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic ccw;
    logic full_step;
    logic start;
  } cfg_t;

  function automatic logic [COIL_W-1:0] coil_lookup(input logic [PHASE_W-1:0] idx);
    logic [COIL_W-1:0] code;
    case (idx)
      3'd0:    code = 4'hA;
      3'd1:    code = 4'h8;
      3'd2:    code = 4'h9;
      3'd3:    code = 4'h1;
      3'd4:    code = 4'h5;
      3'd5:    code = 4'h4;
      3'd6:    code = 4'h6;
      default: code = 4'h2;
    endcase
    return code;
  endfunction

endpackage

### design/sps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_if: stream channels of the stepper phase sequencer
// Tick input channel and coil code result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sps_tick_if;
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface sps_coil_if;
  logic                        valid;
  logic                        ready;
  logic [sps_pkg::COIL_W-1:0]  coil_code;
  logic                        stepped;
  modport source (output valid, output coil_code, output stepped, input ready);
  modport sink   (input valid, input coil_code, input stepped, output ready);
endinterface

### design/stepper_phase_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_unit: four-coil stepper phase sequencer
// Counts millisecond ticks, advances a half/full step phase index on expiry
// and emits the coil code; step period comes from an iterative divider.
// ----------------------------------------------------------------------------
//
//  channel    | dir | handshake             | payload
//  -----------+-----+-----------------------+---------------------------
//  tick_in    | in  | valid/ready           | tick
//  coil_out   | out | valid/ready           | coil_code[3:0], stepped
//  apb        | in  | psel/penable, pready=1| paddr[3:0], pwdata, prdata
//
//  An item goes through accept, one countdown check through the shared
//  subtractor, then the result loads the output register (held while the
//  sink stalls; a new item may be accepted while it waits).
//  A register write restarts the period divider: one quotient bit per cycle,
//  $clog2(TICKS_PER_MINUTE+1) bits (16 at the default), after the registered
//  start flag; ticks are not accepted meanwhile.
//  Reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stepper_phase_sequencer_unit #(
  parameter int unsigned TICKS_PER_MINUTE = sps_pkg::TICKS_PER_MINUTE_DEF,
  parameter int unsigned STEPS_PER_REV    = sps_pkg::STEPS_PER_REV_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sps_tick_if.sink                    tick_in,
  sps_coil_if.source                  coil_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sps_pkg::ADDR_W-1:0]  paddr,
  input  logic [sps_pkg::DATA_W-1:0]  pwdata,
  output logic [sps_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  // Dividend, divisor and shared-unit widths.
  localparam int unsigned DW    = $clog2(TICKS_PER_MINUTE + 1);
  localparam int unsigned DVW   = $clog2(sps_pkg::MAX_RPM * STEPS_PER_REV * 2 + 1);
  localparam int unsigned ALU_W = (DVW + 1 > sps_pkg::PERIOD_W) ? DVW + 1
                                                                : sps_pkg::PERIOD_W;
  localparam int unsigned CNT_W = $clog2(DW);

  localparam int unsigned PW = sps_pkg::PERIOD_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_CHK  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e                        state_q, state_d;
  sps_pkg::cfg_t                 cfg;
  logic [DVW-1:0]                divisor_cfg;

  logic [DVW-1:0]                divisor_q, divisor_d;
  logic [DW-1:0]                 dvd_q, dvd_d;
  logic [DVW-1:0]                rem_q, rem_d;
  logic [DW-1:0]                 quo_q, quo_d;
  logic [CNT_W-1:0]              bit_cnt_q, bit_cnt_d;

  logic [PW-1:0]                 countdown_q, countdown_d;
  logic [PW-1:0]                 reload_q, reload_d;
  logic [sps_pkg::PHASE_W-1:0]   phase_q, phase_d;
  logic                          tick_q, tick_d;
  logic                          step_q, step_d;

  logic                          out_valid_q, out_valid_d;
  logic [sps_pkg::COIL_W-1:0]    out_coil_q, out_coil_d;
  logic                          out_step_q, out_step_d;

  logic [ALU_W-1:0]              alu_a, alu_b, alu_diff;
  logic                          alu_borrow;
  logic [DVW:0]                  rem_sh;
  logic [DW-1:0]                 quo_next;
  logic [PW-1:0]                 quo_sat;
  logic [sps_pkg::PHASE_W-1:0]   move;
  logic                          in_acc;
  logic                          out_free;

  sps_regs #(
    .STEPS_PER_REV (STEPS_PER_REV),
    .DVW           (DVW)
  ) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .divisor_o (divisor_cfg)
  );

  // One subtractor serves both the divider step and the countdown check.
  sps_sub #(
    .W (ALU_W)
  ) u_sub (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .diff_o   (alu_diff),
    .borrow_o (alu_borrow)
  );

  assign rem_sh = {rem_q, dvd_q[DW-1]};

  always_comb begin
    if (state_q == S_DIV) begin
      alu_a = ALU_W'(rem_sh);
      alu_b = ALU_W'(divisor_q);
    end else begin
      alu_a = ALU_W'(countdown_q);
      alu_b = ALU_W'(1);
    end
  end

  // Quotient with this cycle's bit, saturated into the period range.
  assign quo_next = {quo_q[DW-2:0], ~alu_borrow};

  always_comb begin
    if (quo_next > DW'(sps_pkg::PERIOD_MAX)) begin
      quo_sat = PW'(sps_pkg::PERIOD_MAX);
    end else if (quo_next == '0) begin
      quo_sat = PW'(1);
    end else begin
      quo_sat = quo_next[PW-1:0];
    end
  end

  assign move = cfg.full_step ? sps_pkg::PHASE_W'(2) : sps_pkg::PHASE_W'(1);

  assign tick_in.ready = (state_q == S_IDLE) & ~cfg.start;
  assign in_acc        = tick_in.valid & tick_in.ready;
  assign out_free      = ~out_valid_q | coil_out.ready;

  always_comb begin
    state_d     = state_q;
    divisor_d   = divisor_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    bit_cnt_d   = bit_cnt_q;
    countdown_d = countdown_q;
    reload_d    = reload_q;
    phase_d     = phase_q;
    tick_d      = tick_q;
    step_d      = step_q;
    out_valid_d = out_valid_q & ~coil_out.ready;
    out_coil_d  = out_coil_q;
    out_step_d  = out_step_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          tick_d  = tick_in.tick;
          state_d = S_CHK;
        end
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle, MSB first.
        if (alu_borrow) begin
          rem_d = rem_sh[DVW-1:0];
        end else begin
          rem_d = alu_diff[DVW-1:0];
        end
        dvd_d     = dvd_q << 1;
        quo_d     = quo_next;
        bit_cnt_d = bit_cnt_q - CNT_W'(1);
        if (bit_cnt_q == '0) begin
          reload_d = quo_sat;
          state_d  = S_IDLE;
        end
      end
      S_CHK: begin
        step_d = 1'b0;
        if (tick_q) begin
          // Countdown at 0 or 1 expires: step and reload.
          if (alu_borrow || (alu_diff == '0)) begin
            phase_d     = cfg.ccw ? (phase_q - move) : (phase_q + move);
            countdown_d = reload_q;
            step_d      = 1'b1;
          end else begin
            countdown_d = alu_diff[PW-1:0];
          end
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_coil_d  = sps_pkg::coil_lookup(phase_q);
          out_step_d  = step_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A register write restarts the period computation from scratch.
    if (cfg.start) begin
      divisor_d = divisor_cfg;
      dvd_d     = DW'(TICKS_PER_MINUTE);
      rem_d     = '0;
      quo_d     = '0;
      bit_cnt_d = CNT_W'(DW - 1);
      state_d   = S_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      countdown_q <= PW'(sps_pkg::RESET_PERIOD);
      reload_q    <= PW'(sps_pkg::RESET_PERIOD);
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      countdown_q <= countdown_d;
      reload_q    <= reload_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      bit_cnt_q   <= bit_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    divisor_q  <= divisor_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    tick_q     <= tick_d;
    step_q     <= step_d;
    out_coil_q <= out_coil_d;
    out_step_q <= out_step_d;
  end

  assign coil_out.valid     = out_valid_q;
  assign coil_out.coil_code = out_coil_q;
  assign coil_out.stepped   = out_step_q;

  // An accepted item goes straight to the countdown check.
  a_accept_to_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_CHK))
    else $error("accepted item did not enter countdown check");

  // A register write always restarts the divider.
  a_start_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.start |=> (state_q == S_DIV))
    else $error("register write did not restart divider");

  // The step period is never zero and fits the period range.
  a_reload_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (reload_q != '0))
    else $error("reload period is zero");

  // No item is taken while the divider runs.
  a_no_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> !in_acc)
    else $error("item accepted during period division");

endmodule

### design/sps_sub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_sub: shared subtractor
// Computes a - b with borrow; used by the divider and the countdown check.
// ----------------------------------------------------------------------------
module sps_sub #(
  parameter int unsigned W = 17
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] diff_o,
  output logic         borrow_o
);

  logic [W:0] full;

  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[W-1:0];
  assign borrow_o = full[W];

endmodule

### design/sps_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_regs: configuration registers
// APB register file; derives the step-rate divisor and flags a recompute.
// ----------------------------------------------------------------------------
module sps_regs #(
  parameter int unsigned STEPS_PER_REV = sps_pkg::STEPS_PER_REV_DEF,
  parameter int unsigned DVW           = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sps_pkg::ADDR_W-1:0]  paddr,
  input  logic [sps_pkg::DATA_W-1:0]  pwdata,
  output logic [sps_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output sps_pkg::cfg_t               cfg_o,
  output logic [DVW-1:0]              divisor_o
);

  logic                         dir_q, dir_d;
  logic                         full_q, full_d;
  logic [sps_pkg::SPEED_W-1:0]  speed_q, speed_d;
  logic                         start_q, start_d;
  logic                         wr;
  sps_pkg::reg_idx_e            idx;
  logic [sps_pkg::RPM_W-1:0]    rpm;
  logic [DVW-1:0]               prod;

  assign wr     = psel & penable & pwrite;
  assign idx    = sps_pkg::reg_idx_e'(paddr[sps_pkg::ADDR_W-1:2]);
  assign pready = 1'b1;

  always_comb begin
    dir_d   = dir_q;
    full_d  = full_q;
    speed_d = speed_q;
    start_d = 1'b0;
    if (wr) begin
      unique case (idx)
        sps_pkg::REG_DIR: begin
          dir_d   = pwdata[0];
          start_d = 1'b1;
        end
        sps_pkg::REG_FULL: begin
          full_d  = pwdata[0];
          start_d = 1'b1;
        end
        sps_pkg::REG_SPEED: begin
          speed_d = pwdata[sps_pkg::SPEED_W-1:0];
          start_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= 1'b0;
      full_q  <= 1'b0;
      speed_q <= sps_pkg::SPEED_W'(sps_pkg::RESET_SPEED);
      start_q <= 1'b0;
    end else begin
      dir_q   <= dir_d;
      full_q  <= full_d;
      speed_q <= speed_d;
      start_q <= start_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      sps_pkg::REG_DIR:   prdata = sps_pkg::DATA_W'(dir_q);
      sps_pkg::REG_FULL:  prdata = sps_pkg::DATA_W'(full_q);
      sps_pkg::REG_SPEED: prdata = sps_pkg::DATA_W'(speed_q);
      default:            prdata = '0;
    endcase
  end

  // Clamp speed to 1..MAX_RPM, then scale by steps per rev and step factor.
  always_comb begin
    if (speed_q == '0) begin
      rpm = sps_pkg::RPM_W'(1);
    end else if (speed_q > sps_pkg::SPEED_W'(sps_pkg::MAX_RPM)) begin
      rpm = sps_pkg::RPM_W'(sps_pkg::MAX_RPM);
    end else begin
      rpm = speed_q[sps_pkg::RPM_W-1:0];
    end
  end

  assign prod      = DVW'(rpm) * DVW'(STEPS_PER_REV);
  assign divisor_o = full_q ? prod : (prod << 1);

  assign cfg_o.ccw       = dir_q;
  assign cfg_o.full_step = full_q;
  assign cfg_o.start     = start_q;

endmodule
